@@ rtl/rshc_pkg.sv @@
// Shared types and constants for the reciprocating stepper homing control.
package rshc_pkg;

  typedef enum logic [1:0] {
    MS_IDLE = 2'd0,
    MS_FWD  = 2'd1,
    MS_BACK = 2'd2,
    MS_HOME = 2'd3
  } motion_t;

  typedef enum logic [1:0] {
    SC_STOP   = 2'd0,
    SC_PLAY   = 2'd1,
    SC_BYPASS = 2'd2
  } stored_cmd_t;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd2
  } dir_t;

  localparam logic [2:0] CMD_STOP   = 3'd0;
  localparam logic [2:0] CMD_PLAY   = 3'd1;
  localparam logic [2:0] CMD_BYPASS = 3'd2;
  localparam logic [2:0] CMD_FOLLOW = 3'd3;
  localparam logic [2:0] CMD_HOME   = 3'd4;

  localparam logic [1:0] BM_FWD  = 2'd1;
  localparam logic [1:0] BM_BACK = 2'd2;

  localparam logic REG_TRAVEL_LIMIT = 1'b0;
  localparam logic REG_HOME_ZERO    = 1'b1;

  localparam int LIMIT_W = 20;
  localparam int HZ_W    = 32;
  localparam int OUT_W   = 32;

  localparam logic [LIMIT_W-1:0] TRAVEL_LIMIT_RST = 20'd1750;

  typedef struct packed {
    motion_t     motion;
    stored_cmd_t stored;
    motion_t     bypass;
    logic        last_back;
  } ctrl_t;

endpackage

@@ rtl/rshc_step_core.sv @@
// Next-state and step decision for one tick.
module rshc_step_core import rshc_pkg::*; #(
  parameter int POS_WIDTH   = 32,
  parameter int PLAY_MARGIN = 50
) (
  input  ctrl_t                        cur,
  input  logic [POS_WIDTH-1:0]         pos,
  input  logic                         cmd_write,
  input  logic [2:0]                   cmd,
  input  logic [1:0]                   bypass_motion,
  input  logic                         endstop,
  input  logic [LIMIT_W-1:0]           travel_limit,
  input  logic signed [HZ_W-1:0]       home_zero,
  output ctrl_t                        nxt,
  output logic [POS_WIDTH-1:0]         pos_next,
  output dir_t                         dir,
  output logic                         done
);

  localparam int CMP_W = ((POS_WIDTH > HZ_W) ? POS_WIDTH : HZ_W) + 2;

  logic signed [CMP_W-1:0] p_ext;
  logic signed [CMP_W-1:0] hz_ext;
  logic signed [CMP_W-1:0] lim_ext;
  logic signed [CMP_W-1:0] fwd_thr;
  logic signed [CMP_W-1:0] back_thr;

  assign p_ext    = CMP_W'($signed(pos));
  assign hz_ext   = CMP_W'(home_zero);
  assign lim_ext  = $signed(CMP_W'(travel_limit));
  assign fwd_thr  = hz_ext - $signed(CMP_W'(PLAY_MARGIN));
  assign back_thr = hz_ext - lim_ext;

  always_comb begin
    nxt      = cur;
    pos_next = pos;
    dir      = DIR_NONE;
    done     = 1'b0;

    if (cmd_write) begin
      case (cmd)
        CMD_STOP: nxt.stored = SC_STOP;
        CMD_PLAY: nxt.stored = SC_PLAY;
        CMD_BYPASS: begin
          case (bypass_motion)
            BM_FWD:  nxt.bypass = MS_FWD;
            BM_BACK: nxt.bypass = MS_BACK;
            default: nxt.bypass = MS_IDLE;
          endcase
          nxt.stored = SC_BYPASS;
        end
        CMD_FOLLOW: begin
          nxt.stored = SC_PLAY;
          if (nxt.motion inside {MS_HOME, MS_IDLE}) begin
            nxt.motion = MS_FWD;
          end
        end
        CMD_HOME: begin
          nxt.motion = MS_HOME;
          nxt.stored = SC_BYPASS;
          nxt.bypass = MS_IDLE;
        end
        default: ;
      endcase
    end

    if (nxt.motion == MS_HOME) begin
      if (nxt.stored == SC_STOP) begin
        nxt.motion = MS_IDLE;
      end else if (endstop) begin
        nxt.motion = MS_IDLE;
        pos_next   = hz_ext[POS_WIDTH-1:0];
        dir        = DIR_MINUS;
        done       = 1'b1;
      end else begin
        dir = DIR_PLUS;
      end
    end else begin
      case (nxt.stored)
        SC_PLAY: begin
          if (p_ext >= fwd_thr) begin
            nxt.motion = MS_FWD;
          end else if (p_ext <= back_thr) begin
            nxt.motion = MS_BACK;
          end else begin
            nxt.motion = nxt.last_back ? MS_BACK : MS_FWD;
          end
        end
        SC_BYPASS: nxt.motion = nxt.bypass;
        default:   nxt.motion = MS_IDLE;
      endcase

      if (nxt.motion == MS_FWD) begin
        dir           = DIR_MINUS;
        pos_next      = pos - POS_WIDTH'(1);
        nxt.last_back = 1'b0;
      end else if (nxt.motion == MS_BACK) begin
        dir           = DIR_PLUS;
        pos_next      = pos + POS_WIDTH'(1);
        nxt.last_back = 1'b1;
      end
    end
  end

endmodule

@@ rtl/reciprocating_stepper_homing_control_unit.sv @@
// Top level: input register, tick logic, state and result register.
// An accepted word waits in the input register; its tick result is then registered on the output.
// Throughput: one word per cycle unless out_stall holds a result; the combinational tick logic sets the rate.
// in_stall rises only while the input register holds a word and a result is stalled.
// Reset (rst, synchronous): motion idle, command stop, position zero,
// travel_limit 1750, home_zero 0; no words in flight.
module reciprocating_stepper_homing_control_unit import rshc_pkg::*; #(
  parameter int PLAY_MARGIN = 50,
  parameter int POS_WIDTH   = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   cmd_write,
  input  logic [2:0]             cmd,
  input  logic [1:0]             bypass_motion,
  input  logic                   endstop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             step_dir,
  output logic signed [OUT_W-1:0] position,
  output logic [1:0]             motion_state_out,
  output logic                   homing_done,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [HZ_W-1:0]        cfg_data
);

  localparam int EXT_W = ((POS_WIDTH > OUT_W) ? POS_WIDTH : OUT_W) + 1;

  logic                   s1_valid;
  logic                   s1_cmd_write;
  logic [2:0]             s1_cmd;
  logic [1:0]             s1_bypass_motion;
  logic                   s1_endstop;

  ctrl_t                  ctrl;
  ctrl_t                  ctrl_next;
  logic [POS_WIDTH-1:0]   pos;
  logic [POS_WIDTH-1:0]   pos_next;
  dir_t                   dir;
  logic                   done;
  logic [EXT_W-1:0]       pos_ext;

  logic [LIMIT_W-1:0]     travel_limit;
  logic signed [HZ_W-1:0] home_zero;

  logic                   in_acc;
  logic                   advance;

  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && out_valid && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  rshc_step_core #(
    .POS_WIDTH   (POS_WIDTH),
    .PLAY_MARGIN (PLAY_MARGIN)
  ) u_core (
    .cur           (ctrl),
    .pos           (pos),
    .cmd_write     (s1_cmd_write),
    .cmd           (s1_cmd),
    .bypass_motion (s1_bypass_motion),
    .endstop       (s1_endstop),
    .travel_limit  (travel_limit),
    .home_zero     (home_zero),
    .nxt           (ctrl_next),
    .pos_next      (pos_next),
    .dir           (dir),
    .done          (done)
  );

  assign pos_ext = EXT_W'(pos_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      travel_limit <= TRAVEL_LIMIT_RST;
      home_zero    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TRAVEL_LIMIT: travel_limit <= cfg_data[LIMIT_W-1:0];
        REG_HOME_ZERO:    home_zero    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc || (s1_valid && !advance);
    end
    if (in_acc) begin
      s1_cmd_write     <= cmd_write;
      s1_cmd           <= cmd;
      s1_bypass_motion <= bypass_motion;
      s1_endstop       <= endstop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl      <= '{motion: MS_IDLE, stored: SC_STOP, bypass: MS_IDLE, last_back: 1'b0};
      pos       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      ctrl      <= ctrl_next;
      pos       <= pos_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      step_dir         <= dir;
      position         <= $signed(pos_ext[OUT_W-1:0]);
      motion_state_out <= ctrl_next.motion;
      homing_done      <= done;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("words in flight after reset");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with nothing held");

  a_done_backoff: assert property (@(posedge clk) disable iff (rst)
    out_valid && homing_done |->
      step_dir == DIR_MINUS && motion_state_out == MS_IDLE)
    else $error("homing done without back-off step");

  a_homing_steps_plus: assert property (@(posedge clk) disable iff (rst)
    out_valid && motion_state_out == MS_HOME |-> step_dir == DIR_PLUS && !homing_done)
    else $error("homing word without plus step");

  a_idle_no_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && motion_state_out == MS_IDLE && !homing_done |-> step_dir == DIR_NONE)
    else $error("idle word carries a step");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the reciprocating stepper homing control unit.
module testbench;
  import rshc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] BM_IDLE = 2'd0;
  localparam logic [1:0] BM_UNDEF = 2'd3;
  localparam logic [2:0] CMD_UNDEF_LO = 3'd5;
  localparam logic [2:0] CMD_UNDEF_HI = 3'd7;
  localparam longint PLAY_MARGIN = 50;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    dir_t               dir;
    logic signed [31:0] pos;
    motion_t            motion;
    logic               done;
  } tick_t;

  typedef struct packed {
    logic       wr;
    logic [2:0] cmd;
    logic [1:0] bm;
    logic       es;
    logic       fixed;
    tick_t      want;
  } stim_t;

  localparam tick_t FREE = '0;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic cmd_write;
  logic [2:0] cmd;
  logic [1:0] bypass_motion;
  logic endstop;
  logic out_valid;
  logic out_stall;
  logic [1:0] step_dir;
  logic signed [31:0] position;
  logic [1:0] motion_state_out;
  logic homing_done;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [31:0] cfg_data;

  reciprocating_stepper_homing_control_unit u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd_write(cmd_write),
    .cmd(cmd),
    .bypass_motion(bypass_motion),
    .endstop(endstop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .step_dir(step_dir),
    .position(position),
    .motion_state_out(motion_state_out),
    .homing_done(homing_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predicted copy of the block's state and registers.
  motion_t            m_motion;
  stored_cmd_t        m_cmd;
  motion_t            m_bypass;
  motion_t            m_last;
  logic signed [31:0] m_pos;
  logic [19:0]        m_limit;
  logic [31:0]        m_home;

  tick_t pending_ticks[$];
  stim_t stim_words[$];
  int mismatch_count = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int calm_tx = 0;
  int calm_rx = 0;

  stim_t dir_table[24] = '{
    '{1'b0, CMD_STOP,     BM_IDLE,  1'b0, 1'b1, '{DIR_NONE,  32'sd0,  MS_IDLE, 1'b0}},
    '{1'b1, CMD_BYPASS,   BM_FWD,   1'b0, 1'b1, '{DIR_MINUS, -32'sd1, MS_FWD,  1'b0}},
    '{1'b1, CMD_BYPASS,   BM_BACK,  1'b0, 1'b1, '{DIR_PLUS,  32'sd0,  MS_BACK, 1'b0}},
    '{1'b1, CMD_BYPASS,   BM_UNDEF, 1'b1, 1'b1, '{DIR_NONE,  32'sd0,  MS_IDLE, 1'b0}},
    '{1'b1, CMD_BYPASS,   BM_IDLE,  1'b0, 1'b1, '{DIR_NONE,  32'sd0,  MS_IDLE, 1'b0}},
    '{1'b1, CMD_HOME,     BM_UNDEF, 1'b0, 1'b1, '{DIR_PLUS,  32'sd0,  MS_HOME, 1'b0}},
    '{1'b0, CMD_UNDEF_HI, BM_IDLE,  1'b0, 1'b1, '{DIR_PLUS,  32'sd0,  MS_HOME, 1'b0}},
    '{1'b0, CMD_STOP,     BM_IDLE,  1'b1, 1'b1, '{DIR_MINUS, 32'sd0,  MS_IDLE, 1'b1}},
    '{1'b0, CMD_STOP,     BM_IDLE,  1'b0, 1'b1, '{DIR_NONE,  32'sd0,  MS_IDLE, 1'b0}},
    '{1'b1, CMD_HOME,     BM_IDLE,  1'b1, 1'b1, '{DIR_MINUS, 32'sd0,  MS_IDLE, 1'b1}},
    '{1'b1, CMD_HOME,     BM_IDLE,  1'b0, 1'b1, '{DIR_PLUS,  32'sd0,  MS_HOME, 1'b0}},
    '{1'b1, CMD_STOP,     BM_IDLE,  1'b1, 1'b1, '{DIR_NONE,  32'sd0,  MS_IDLE, 1'b0}},
    '{1'b1, CMD_PLAY,     BM_IDLE,  1'b0, 1'b1, '{DIR_MINUS, -32'sd1, MS_FWD,  1'b0}},
    '{1'b1, CMD_UNDEF_LO, BM_BACK,  1'b0, 1'b0, FREE},
    '{1'b1, CMD_UNDEF_HI, BM_UNDEF, 1'b1, 1'b0, FREE},
    '{1'b1, CMD_FOLLOW,   BM_IDLE,  1'b0, 1'b0, FREE},
    '{1'b1, CMD_STOP,     BM_FWD,   1'b0, 1'b0, FREE},
    '{1'b1, CMD_FOLLOW,   BM_IDLE,  1'b0, 1'b0, FREE},
    '{1'b1, CMD_HOME,     BM_BACK,  1'b0, 1'b0, FREE},
    '{1'b1, CMD_FOLLOW,   BM_IDLE,  1'b0, 1'b0, FREE},
    '{1'b1, CMD_HOME,     BM_FWD,   1'b0, 1'b0, FREE},
    '{1'b1, CMD_BYPASS,   BM_BACK,  1'b0, 1'b0, FREE},
    '{1'b0, CMD_PLAY,     BM_IDLE,  1'b1, 1'b0, FREE},
    '{1'b0, CMD_UNDEF_HI, BM_UNDEF, 1'b1, 1'b0, FREE}
  };

  function automatic tick_t advance_motion(input stim_t w);
    tick_t r;
    longint p;
    longint hz;
    r = '0;
    if (w.wr) begin
      case (w.cmd)
        CMD_STOP: m_cmd = SC_STOP;
        CMD_PLAY: m_cmd = SC_PLAY;
        CMD_BYPASS: begin
          m_cmd = SC_BYPASS;
          m_bypass = (w.bm == BM_FWD) ? MS_FWD : (w.bm == BM_BACK) ? MS_BACK : MS_IDLE;
        end
        CMD_FOLLOW: begin
          m_cmd = SC_PLAY;
          if (m_motion == MS_HOME || m_motion == MS_IDLE) m_motion = MS_FWD;
        end
        CMD_HOME: begin
          m_motion = MS_HOME;
          m_cmd = SC_BYPASS;
          m_bypass = MS_IDLE;
        end
        default: ;
      endcase
    end
    r.dir = DIR_NONE;
    if (m_motion == MS_HOME) begin
      if (m_cmd == SC_STOP) begin
        m_motion = MS_IDLE;
      end else if (w.es) begin
        m_motion = MS_IDLE;
        m_pos = m_home;
        r.dir = DIR_MINUS;
        r.done = 1'b1;
      end else begin
        r.dir = DIR_PLUS;
      end
    end else begin
      p = longint'(m_pos);
      hz = longint'($signed(m_home));
      case (m_cmd)
        SC_PLAY: begin
          if (p >= hz - PLAY_MARGIN) m_motion = MS_FWD;
          else if (p <= hz - longint'(m_limit)) m_motion = MS_BACK;
          else m_motion = m_last;
        end
        SC_BYPASS: m_motion = m_bypass;
        default: m_motion = MS_IDLE;
      endcase
      if (m_motion == MS_FWD) begin
        r.dir = DIR_MINUS;
        m_pos = m_pos - 32'sd1;
        m_last = MS_FWD;
      end else if (m_motion == MS_BACK) begin
        r.dir = DIR_PLUS;
        m_pos = m_pos + 32'sd1;
        m_last = MS_BACK;
      end
    end
    r.pos = m_pos;
    r.motion = m_motion;
    return r;
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic stim_t make_word(input logic wr, input logic [2:0] c, input logic es);
    stim_t w;
    w = '0;
    w.wr = wr;
    w.cmd = c;
    w.bm = 2'($urandom_range(0, 3));
    w.es = es;
    return w;
  endfunction

  task automatic build_words(input int n, input int span);
    int base;
    int k;
    int r;
    base = stim_words.size();
    while (stim_words.size() - base < n) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        stim_words.push_back(make_word(1'b1, CMD_HOME, 1'b0));
        k = $urandom_range(0, 8);
        repeat (k) stim_words.push_back(make_word(1'b0, 3'($urandom_range(0, 7)), 1'b0));
        stim_words.push_back(make_word(1'b0, 3'($urandom_range(0, 7)), 1'b1));
        stim_words.push_back(make_word(1'b1, $urandom_range(0, 1) ? CMD_PLAY : CMD_FOLLOW,
                                       1'($urandom_range(0, 1))));
        k = $urandom_range(10, 2 * span + 120);
        if (k > n - (stim_words.size() - base) + 5) k = n - (stim_words.size() - base) + 5;
        repeat (k) begin
          stim_words.push_back(make_word($urandom_range(0, 40) == 0,
                                         3'($urandom_range(0, 4)),
                                         1'($urandom_range(0, 1))));
        end
      end else if (r < 8) begin
        stim_words.push_back(make_word(1'b1, CMD_BYPASS, 1'($urandom_range(0, 1))));
        k = $urandom_range(1, 20);
        repeat (k) begin
          stim_words.push_back(make_word(1'b0, 3'($urandom_range(0, 7)),
                                         1'($urandom_range(0, 1))));
        end
      end else begin
        k = $urandom_range(1, 10);
        repeat (k) begin
          stim_words.push_back(make_word(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                         1'($urandom_range(0, 1))));
        end
      end
    end
  endtask

  task automatic drive_words();
    stim_t w;
    tick_t predicted;
    int gap;
    while (stim_words.size() > 0) begin
      w = stim_words.pop_front();
      gap = pick_gap(calm_tx);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      cmd_write <= w.wr;
      cmd <= w.cmd;
      bypass_motion <= w.bm;
      endstop <= w.es;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      predicted = advance_motion(w);
      pending_ticks.push_back(w.fixed ? w.want : predicted);
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_TRAVEL_LIMIT) m_limit = data[19:0];
    else m_home = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [19:0] limit, input logic [31:0] home, input int n);
    drain();
    write_reg(REG_TRAVEL_LIMIT, {12'd0, limit});
    write_reg(REG_HOME_ZERO, home);
    build_words(n, (limit < 20'd300) ? int'(limit) : 300);
    drive_words();
  endtask

  initial begin : stimulus
    rst = 1'b1;
    in_valid = 1'b0;
    cmd_write = 1'b0;
    cmd = CMD_STOP;
    bypass_motion = BM_IDLE;
    endstop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_TRAVEL_LIMIT;
    cfg_data = '0;
    m_motion = MS_IDLE;
    m_cmd = SC_STOP;
    m_bypass = MS_IDLE;
    m_last = MS_FWD;
    m_pos = '0;
    m_limit = TRAVEL_LIMIT_RST;
    m_home = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_table[i]) stim_words.push_back(dir_table[i]);
    drive_words();
    run_phase(20'd100, 32'd0, 300);
    run_phase(20'd0, 32'h7FFF_FFFF, 250);
    run_phase(20'd60, 32'h8000_0000, 250);
    run_phase(20'hF_FFFF, $urandom, 250);
    run_phase(TRAVEL_LIMIT_RST, $urandom, 300);
    repeat (2) run_phase(20'($urandom_range(0, 400)), $urandom, 300);
    drain();
    if (mismatch_count == 0) begin
      $display("reciprocating_stepper_homing_control_unit verification clean");
    end else begin
      $display("reciprocating_stepper_homing_control_unit verification failed");
    end
    $finish;
  end

  initial begin : receiver
    int hold;
    bit long_hold_done;
    long_hold_done = 1'b0;
    out_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && results_seen >= 150) begin
        long_hold_done = 1'b1;
        hold = LONG_HOLD;
      end else begin
        hold = pick_gap(calm_rx);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    tick_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_ticks.size() == 0) begin
        $display("%0t: unexpected word dir %0d pos %0d state %0d done %0d", $time,
                 step_dir, position, motion_state_out, homing_done);
        mismatch_count++;
      end else begin
        want = pending_ticks.pop_front();
        if (step_dir !== want.dir) begin
          $display("%0t: step_dir expected %0d got %0d", $time, want.dir, step_dir);
          mismatch_count++;
        end
        if (position !== want.pos) begin
          $display("%0t: position expected %0d got %0d", $time, want.pos, position);
          mismatch_count++;
        end
        if (motion_state_out !== want.motion) begin
          $display("%0t: motion_state_out expected %0d got %0d", $time, want.motion,
                   motion_state_out);
          mismatch_count++;
        end
        if (homing_done !== want.done) begin
          $display("%0t: homing_done expected %0d got %0d", $time, want.done, homing_done);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("reciprocating_stepper_homing_control_unit verification failed");
    $finish;
  end

endmodule
